// ----- rtl/circle_pair_collision_unit_defines.svh -----
// ----------------------------------------------------------------------------
// circle_pair_collision_unit_defines
// Assertion macros for the pair collision unit.
// ----------------------------------------------------------------------------
`ifndef CIRCLE_PAIR_COLLISION_UNIT_DEFINES_SVH
`define CIRCLE_PAIR_COLLISION_UNIT_DEFINES_SVH
// implication checked every clock outside reset
`define CPC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cpc check failed");
// next-cycle implication
`define CPC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cpc check failed");
`endif

// ----- rtl/cpc_pkg.sv -----
// ----------------------------------------------------------------------------
// cpc_pkg
// Widths and constants shared by the circle pair collision unit.
// ----------------------------------------------------------------------------
package cpc_pkg;
    localparam int COORD_INT_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF      = 8;
    localparam int RAD_W              = 16;
    localparam int VEL_W              = 15;
    localparam int REST_W             = 9;
    localparam int NORM_FRAC          = 16;
    localparam int LIM_W              = 18;
    localparam int D2_W               = 36;
    localparam int DIST_W             = 18;
    localparam logic [REST_W-1:0] REST_RESET = 9'd205;
endpackage

// ----- rtl/cpc_sqrt_stage.sv -----
// ----------------------------------------------------------------------------
// cpc_sqrt_stage
// One registered step of a restoring integer square root, two result bits.
// ----------------------------------------------------------------------------
module cpc_sqrt_stage #(
    parameter int STEP = 0
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic [cpc_pkg::D2_W-1:0]    rem_in,
    input  logic [cpc_pkg::DIST_W-1:0]  root_in,
    output logic [cpc_pkg::D2_W-1:0]    rem_out,
    output logic [cpc_pkg::DIST_W-1:0]  root_out
);
    import cpc_pkg::*;

    localparam int SH0 = 2 * (DIST_W - 1 - 2 * STEP);
    localparam int SH1 = SH0 - 2;

    logic [D2_W-1:0]   rem_reg, rem_next;
    logic [DIST_W-1:0] root_reg, root_next;

    always_comb
    begin
        logic [D2_W+1:0] trial;
        logic [D2_W-1:0] r;
        logic [DIST_W-1:0] q;
        r = rem_in;
        q = root_in;
        trial = ({2'b00, q, 2'b01} << SH0);
        if ({2'b00, r} >= trial)
        begin
            r = r - trial[D2_W-1:0];
            q = {q[DIST_W-2:0], 1'b1};
        end
        else
        begin
            q = {q[DIST_W-2:0], 1'b0};
        end
        trial = ({2'b00, q, 2'b01} << SH1);
        if ({2'b00, r} >= trial)
        begin
            r = r - trial[D2_W-1:0];
            q = {q[DIST_W-2:0], 1'b1};
        end
        else
        begin
            q = {q[DIST_W-2:0], 1'b0};
        end
        rem_next  = r;
        root_next = q;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign rem_out  = rem_reg;
    assign root_out = root_reg;
endmodule

// ----- rtl/cpc_div_stage.sv -----
// ----------------------------------------------------------------------------
// cpc_div_stage
// One registered step of a restoring divider, two quotient bits.
// ----------------------------------------------------------------------------
module cpc_div_stage #(
    parameter int NUM_W = 34,
    parameter int DEN_W = 18
) (
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num_in,
    input  logic [DEN_W:0]   rem_in,
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] num_out,
    output logic [DEN_W:0]   rem_out
);
    logic [NUM_W-1:0] num_reg, num_next;
    logic [DEN_W:0]   rem_reg, rem_next;

    always_comb
    begin
        logic [DEN_W:0]   r;
        logic [NUM_W-1:0] n;
        r = rem_in;
        n = num_in;
        for (int i = 0; i < 2; i++)
        begin
            r = {r[DEN_W-1:0], n[NUM_W-1]};
            n = {n[NUM_W-2:0], 1'b0};
            if (r >= {1'b0, den})
            begin
                r = r - {1'b0, den};
                n[0] = 1'b1;
            end
        end
        num_next = n;
        rem_next = r;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    assign num_out = num_reg;
    assign rem_out = rem_reg;
endmodule

// ----- rtl/circle_pair_collision_unit.sv -----
// Throughput: one pair per cycle unless the output stalls; sqrt and normal dividers are unrolled into
// two-bit register stages, so the divider chains set the depth.
// Stalls freeze the whole pipeline; no beat is lost or repeated.
// Reset: valid bits clear, restitution returns to 205.
// ----------------------------------------------------------------------------
// circle_pair_collision_unit
// Pipelined circle pair collision test and response.
// ----------------------------------------------------------------------------
`include "circle_pair_collision_unit_defines.svh"
module circle_pair_collision_unit #(
    parameter int COORD_INT_BITS = cpc_pkg::COORD_INT_BITS_DEF,
    parameter int FRAC_BITS      = cpc_pkg::FRAC_BITS_DEF,
    parameter int POS_W          = COORD_INT_BITS + FRAC_BITS,
    parameter int IN_W  = ((4 * POS_W + 2 * cpc_pkg::RAD_W + 4 * cpc_pkg::VEL_W + 7) / 8) * 8,
    parameter int OUT_W = ((4 * POS_W + 4 * cpc_pkg::VEL_W + 2 + 7) / 8) * 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [cpc_pkg::REST_W-1:0]    cfg_wr_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // a_pos_x, a_pos_y, a_radius, a_vel_x, a_vel_y,
    // b_pos_x, b_pos_y, b_radius, b_vel_x, b_vel_y
    input  logic [IN_W-1:0]               s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // new_a_pos_x, new_a_pos_y, new_a_vel_x, new_a_vel_y,
    // new_b_pos_x, new_b_pos_y, new_b_vel_x, new_b_vel_y, hit, coincident
    output logic [OUT_W-1:0]              m_axis_tdata
);
    import cpc_pkg::*;

    localparam int SQ_STEPS  = DIST_W / 2;
    localparam int NUM_W     = LIM_W - 1 + NORM_FRAC;
    localparam int DV_STEPS  = (NUM_W + 1) / 2;
    localparam int NUM_WE    = 2 * DV_STEPS;
    localparam int NRM_W     = NORM_FRAC + 2;
    localparam int DEPTH     = 2 + SQ_STEPS + DV_STEPS + 5;
    localparam int RS_W      = RAD_W + 1;
    localparam int SV_W      = VEL_W + 2;
    localparam int SQ_W      = 2 * (LIM_W - 1);

    typedef struct packed {
        logic [POS_W-1:0]  ax, ay, bx, by;
        logic [RAD_W:0]    rsum;
        logic signed [VEL_W-1:0] avx, avy, bvx, bvy;
        logic              sx, sy;
        logic [LIM_W-2:0]  mdx, mdy;
        logic              hit, coin;
    } side_t;

    logic [REST_W-1:0] rest_reg;
    logic [DEPTH-1:0]  vld_reg;
    logic              en;

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rest_reg <= REST_RESET;
            vld_reg  <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                rest_reg <= cfg_wr_data;
            if (en)
                vld_reg <= {vld_reg[DEPTH-2:0], s_axis_tvalid};
        end
    end

    // ---- stage 0: differences, range and coincidence checks
    side_t s0_next, s0_reg;

    always_comb
    begin
        logic signed [POS_W:0] dx, dy;
        logic [POS_W-1:0] adx, ady;
        logic inr;
        s0_next.ax  = s_axis_tdata[0 +: POS_W];
        s0_next.ay  = s_axis_tdata[POS_W +: POS_W];
        s0_next.avx = s_axis_tdata[2*POS_W+RAD_W +: VEL_W];
        s0_next.avy = s_axis_tdata[2*POS_W+RAD_W+VEL_W +: VEL_W];
        s0_next.bx  = s_axis_tdata[2*POS_W+RAD_W+2*VEL_W +: POS_W];
        s0_next.by  = s_axis_tdata[3*POS_W+RAD_W+2*VEL_W +: POS_W];
        s0_next.bvx = s_axis_tdata[4*POS_W+2*RAD_W+2*VEL_W +: VEL_W];
        s0_next.bvy = s_axis_tdata[4*POS_W+2*RAD_W+3*VEL_W +: VEL_W];
        s0_next.rsum = {1'b0, s_axis_tdata[2*POS_W +: RAD_W]}
                     + {1'b0, s_axis_tdata[4*POS_W+RAD_W+2*VEL_W +: RAD_W]};
        dx = $signed({1'b0, s0_next.ax}) - $signed({1'b0, s0_next.bx});
        dy = $signed({1'b0, s0_next.ay}) - $signed({1'b0, s0_next.by});
        adx = dx[POS_W] ? POS_W'(-dx) : dx[POS_W-1:0];
        ady = dy[POS_W] ? POS_W'(-dy) : dy[POS_W-1:0];
        s0_next.sx = dx[POS_W];
        s0_next.sy = dy[POS_W];
        inr = ({{(LIM_W > POS_W ? LIM_W - POS_W : 1){1'b0}}, adx} < (1 << (LIM_W - 1)))
           && ({{(LIM_W > POS_W ? LIM_W - POS_W : 1){1'b0}}, ady} < (1 << (LIM_W - 1)));
        s0_next.mdx = (LIM_W-1)'(adx);
        s0_next.mdy = (LIM_W-1)'(ady);
        s0_next.coin = (adx == '0) && (ady == '0);
        // hit candidate; the overlap test follows in stage 1
        s0_next.hit  = inr && !s0_next.coin;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            s0_reg <= s0_next;
    end

    // ---- stage 1: squares, hit test
    side_t s1_next, s1_reg;
    logic [D2_W-1:0] d2_next, d2_reg;

    always_comb
    begin
        logic [SQ_W-1:0] sqx, sqy;
        logic [D2_W:0] d2w;
        logic [2*RS_W-1:0] r2;
        s1_next = s0_reg;
        sqx = SQ_W'(s0_reg.mdx) * SQ_W'(s0_reg.mdx);
        sqy = SQ_W'(s0_reg.mdy) * SQ_W'(s0_reg.mdy);
        d2w = (D2_W+1)'(sqx) + (D2_W+1)'(sqy);
        r2 = (2*RS_W)'(s0_reg.rsum) * (2*RS_W)'(s0_reg.rsum);
        s1_next.hit = s0_reg.hit && ((D2_W+1)'(r2) > d2w);
        d2_next = d2w[D2_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= s1_next;
            d2_reg <= d2_next;
        end
    end

    // ---- square root stages
    side_t            sq_side [SQ_STEPS+1];
    logic [D2_W-1:0]  sq_rem  [SQ_STEPS+1];
    logic [DIST_W-1:0] sq_root [SQ_STEPS+1];
    assign sq_side[0] = s1_reg;
    assign sq_rem[0]  = d2_reg;
    assign sq_root[0] = '0;

    for (genvar g = 0; g < SQ_STEPS; g++)
    begin : g_sq
        side_t sd_reg;
        cpc_sqrt_stage #(.STEP(g)) u_st (
            .clk(clk), .en(en),
            .rem_in(sq_rem[g]), .root_in(sq_root[g]),
            .rem_out(sq_rem[g+1]), .root_out(sq_root[g+1])
        );
        always_ff @(posedge clk)
        begin
            if (en)
                sd_reg <= sq_side[g];
        end
        assign sq_side[g+1] = sd_reg;
    end

    // ---- normal dividers
    logic [DIST_W-1:0] dist_q;
    assign dist_q = (sq_root[SQ_STEPS] == '0) ? DIST_W'(1) : sq_root[SQ_STEPS];

    side_t             dv_side [DV_STEPS+1];
    logic [DIST_W-1:0] dv_dist [DV_STEPS+1];
    logic [NUM_WE-1:0] nx_n [DV_STEPS+1];
    logic [NUM_WE-1:0] ny_n [DV_STEPS+1];
    logic [DIST_W:0]   nx_r [DV_STEPS+1];
    logic [DIST_W:0]   ny_r [DV_STEPS+1];
    assign dv_side[0] = sq_side[SQ_STEPS];
    assign dv_dist[0] = dist_q;
    assign nx_n[0] = NUM_WE'({sq_side[SQ_STEPS].mdx, {NORM_FRAC{1'b0}}});
    assign ny_n[0] = NUM_WE'({sq_side[SQ_STEPS].mdy, {NORM_FRAC{1'b0}}});
    assign nx_r[0] = '0;
    assign ny_r[0] = '0;

    for (genvar g = 0; g < DV_STEPS; g++)
    begin : g_dv
        side_t sd_reg;
        logic [DIST_W-1:0] dd_reg;
        cpc_div_stage #(.NUM_W(NUM_WE), .DEN_W(DIST_W)) u_dx (
            .clk(clk), .en(en), .num_in(nx_n[g]), .rem_in(nx_r[g]),
            .den(dv_dist[g]), .num_out(nx_n[g+1]), .rem_out(nx_r[g+1])
        );
        cpc_div_stage #(.NUM_W(NUM_WE), .DEN_W(DIST_W)) u_dy (
            .clk(clk), .en(en), .num_in(ny_n[g]), .rem_in(ny_r[g]),
            .den(dv_dist[g]), .num_out(ny_n[g+1]), .rem_out(ny_r[g+1])
        );
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sd_reg <= dv_side[g];
                dd_reg <= dv_dist[g];
            end
        end
        assign dv_side[g+1] = sd_reg;
        assign dv_dist[g+1] = dd_reg;
    end

    // ---- stage A: signed normal, relative velocity, overlap
    // |n| never exceeds 2^16, so 17 magnitude bits are enough
    side_t p1_reg;
    logic signed [NRM_W-1:0] nx1_reg, ny1_reg;
    logic signed [VEL_W:0]   rvx1_reg, rvy1_reg;
    logic signed [RS_W+1:0]  ov1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg  <= dv_side[DV_STEPS];
            nx1_reg <= dv_side[DV_STEPS].sx ? -$signed({1'b0, nx_n[DV_STEPS][NRM_W-2:0]})
                                            :  $signed({1'b0, nx_n[DV_STEPS][NRM_W-2:0]});
            ny1_reg <= dv_side[DV_STEPS].sy ? -$signed({1'b0, ny_n[DV_STEPS][NRM_W-2:0]})
                                            :  $signed({1'b0, ny_n[DV_STEPS][NRM_W-2:0]});
            rvx1_reg <= (VEL_W+1)'(dv_side[DV_STEPS].avx) - (VEL_W+1)'(dv_side[DV_STEPS].bvx);
            rvy1_reg <= (VEL_W+1)'(dv_side[DV_STEPS].avy) - (VEL_W+1)'(dv_side[DV_STEPS].bvy);
            ov1_reg  <= $signed({2'b00, dv_side[DV_STEPS].rsum})
                      - $signed({1'b0, (RS_W+1)'(dv_dist[DV_STEPS])});
        end
    end

    // ---- stage B: products along the normal, restitution times normal, normal times overlap
    localparam int PR_W = VEL_W + 1 + NRM_W;
    localparam int RN_W = NRM_W + REST_W + 1;
    side_t p2_reg;
    logic signed [RN_W-1:0]   rnx2_reg, rny2_reg;
    logic signed [PR_W-1:0]   px2_reg, py2_reg;
    logic signed [63:0]       mx2_reg, my2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p2_reg   <= p1_reg;
            rnx2_reg <= RN_W'(nx1_reg * $signed({1'b0, rest_reg}));
            rny2_reg <= RN_W'(ny1_reg * $signed({1'b0, rest_reg}));
            px2_reg  <= PR_W'(rvx1_reg * nx1_reg);
            py2_reg  <= PR_W'(rvy1_reg * ny1_reg);
            mx2_reg  <= 64'(nx1_reg * ov1_reg);
            my2_reg  <= 64'(ny1_reg * ov1_reg);
        end
    end

    // ---- stage C: relative normal speed
    side_t p3_reg;
    logic signed [RN_W-1:0] rnx3_reg, rny3_reg;
    logic signed [PR_W:0]   rel3_reg;
    logic signed [63:0] mx3_reg, my3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p3_reg   <= p2_reg;
            rnx3_reg <= rnx2_reg;
            rny3_reg <= rny2_reg;
            rel3_reg <= (PR_W+1)'(px2_reg) + (PR_W+1)'(py2_reg);
            mx3_reg  <= mx2_reg;
            my3_reg  <= my2_reg;
        end
    end

    // ---- stage D: velocity change products
    side_t p4_reg;
    logic signed [79:0] cx4_reg, cy4_reg;
    logic signed [63:0] mx4_reg, my4_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p4_reg  <= p3_reg;
            cx4_reg <= 80'(rel3_reg * rnx3_reg);
            cy4_reg <= 80'(rel3_reg * rny3_reg);
            mx4_reg <= mx3_reg;
            my4_reg <= my3_reg;
        end
    end

    // ---- stage E: round, apply, saturate
    function automatic logic signed [63:0] rnd80(input logic signed [79:0] v, input int s);
        logic [79:0] m;
        m = v[79] ? 80'(-v) : 80'(v);
        m = (m + (80'(1) << (s - 1))) >> s;
        return v[79] ? -$signed(64'(m)) : $signed(64'(m));
    endfunction

    function automatic logic [POS_W-1:0] sat_p(input logic signed [63:0] v);
        if (v < 0)
            return '0;
        else if (v > $signed(64'((64'(1) << POS_W) - 1)))
            return '1;
        return POS_W'(v);
    endfunction

    function automatic logic [VEL_W-1:0] sat_v(input logic signed [63:0] v);
        if (v < -64'sd16384)
            return VEL_W'(15'h4000);
        else if (v > 64'sd16383)
            return VEL_W'(15'h3FFF);
        return VEL_W'(v);
    endfunction

    logic [OUT_W-1:0] out_reg, out_next;
    always_comb
    begin
        logic signed [63:0] cx, cy, mx, my;
        side_t p;
        p  = p4_reg;
        cx = rnd80(cx4_reg, 2 * NORM_FRAC + 8);
        cy = rnd80(cy4_reg, 2 * NORM_FRAC + 8);
        mx = rnd80(80'(mx4_reg), NORM_FRAC + 1);
        my = rnd80(80'(my4_reg), NORM_FRAC + 1);
        out_next = '0;
        if (p.hit)
        begin
            out_next[0 +: POS_W]                 = sat_p($signed(64'(p.ax)) + mx);
            out_next[POS_W +: POS_W]             = sat_p($signed(64'(p.ay)) + my);
            out_next[2*POS_W +: VEL_W]           = sat_v(64'(p.avx) - cx);
            out_next[2*POS_W+VEL_W +: VEL_W]     = sat_v(64'(p.avy) - cy);
            out_next[2*POS_W+2*VEL_W +: POS_W]   = sat_p($signed(64'(p.bx)) - mx);
            out_next[3*POS_W+2*VEL_W +: POS_W]   = sat_p($signed(64'(p.by)) - my);
            out_next[4*POS_W+2*VEL_W +: VEL_W]   = sat_v(64'(p.bvx) + cx);
            out_next[4*POS_W+3*VEL_W +: VEL_W]   = sat_v(64'(p.bvy) + cy);
        end
        else
        begin
            out_next[0 +: POS_W]                 = p.ax;
            out_next[POS_W +: POS_W]             = p.ay;
            out_next[2*POS_W +: VEL_W]           = p.avx;
            out_next[2*POS_W+VEL_W +: VEL_W]     = p.avy;
            out_next[2*POS_W+2*VEL_W +: POS_W]   = p.bx;
            out_next[3*POS_W+2*VEL_W +: POS_W]   = p.by;
            out_next[4*POS_W+2*VEL_W +: VEL_W]   = p.bvx;
            out_next[4*POS_W+3*VEL_W +: VEL_W]   = p.bvy;
        end
        out_next[4*POS_W+4*VEL_W]     = p.hit;
        out_next[4*POS_W+4*VEL_W+1]   = p.coin;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_reg <= out_next;
    end

    assign m_axis_tdata = out_reg;

    `CPC_ASSERT_IMP(a_no_hit_coin, m_axis_tvalid,
        !(m_axis_tdata[4*POS_W+4*VEL_W] && m_axis_tdata[4*POS_W+4*VEL_W+1]))
    `CPC_ASSERT_NEXT(a_stall_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata))
    `CPC_ASSERT_IMP(a_ready_rule, !m_axis_tvalid, s_axis_tready)
endmodule

// ----- test/tb_circle_pair_collision_unit.sv -----
// ----------------------------------------------------------------------------
// tb_circle_pair_collision_unit
// Drives circle pairs into the collision unit and checks every result beat
// against a fixed-point collision predictor, under random idling, a long
// receiver hold-off and several restitution settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_circle_pair_collision_unit;
    import cpc_pkg::*;

    localparam int POS_W = COORD_INT_BITS_DEF + FRAC_BITS_DEF;
    localparam int IN_W  = ((4 * POS_W + 2 * RAD_W + 4 * VEL_W + 7) / 8) * 8;
    localparam int OUT_W = ((4 * POS_W + 4 * VEL_W + 2 + 7) / 8) * 8;
    localparam int LATENCY = 33;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int N_RANDOM = 1400;
    localparam logic [POS_W-1:0] POS_MAX = '1;
    localparam int VEL_MAX = 16383;
    localparam int VEL_MIN = -16384;

    typedef struct packed {
        logic signed [VEL_W-1:0] b_vel_y;
        logic signed [VEL_W-1:0] b_vel_x;
        logic [RAD_W-1:0]        b_radius;
        logic [POS_W-1:0]        b_pos_y;
        logic [POS_W-1:0]        b_pos_x;
        logic signed [VEL_W-1:0] a_vel_y;
        logic signed [VEL_W-1:0] a_vel_x;
        logic [RAD_W-1:0]        a_radius;
        logic [POS_W-1:0]        a_pos_y;
        logic [POS_W-1:0]        a_pos_x;
    } pair_t;

    typedef struct packed {
        logic                    coincident;
        logic                    hit;
        logic signed [VEL_W-1:0] b_vel_y;
        logic signed [VEL_W-1:0] b_vel_x;
        logic [POS_W-1:0]        b_pos_y;
        logic [POS_W-1:0]        b_pos_x;
        logic signed [VEL_W-1:0] a_vel_y;
        logic signed [VEL_W-1:0] a_vel_x;
        logic [POS_W-1:0]        a_pos_y;
        logic [POS_W-1:0]        a_pos_x;
    } resp_t;

    typedef struct {
        pair_t pair;
        bit    has_fixed;
        resp_t fixed;
    } directed_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [REST_W-1:0] cfg_wr_data = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;

    logic [REST_W-1:0] restitution_q = REST_RESET;
    resp_t expected_resp_q[$];
    int mismatch_count = 0;
    int idle_cycles = 0;
    bit timed_out = 0;
    bit hold_off = 0;
    bit stim_done = 0;
    directed_row_t directed_rows[$];

    circle_pair_collision_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always #5 clk = ~clk;

    function automatic longint round_shift(longint v, int s);
        longint m;
        m = (v < 0) ? -v : v;
        m = (m + (64'sd1 <<< (s - 1))) >>> s;
        return (v < 0) ? -m : m;
    endfunction

    function automatic longint isqrt(longint x);
        longint r;
        r = 0;
        for (int b = 18; b >= 0; b--)
        begin
            if ((r + (64'sd1 << b)) * (r + (64'sd1 << b)) <= x)
                r = r + (64'sd1 << b);
        end
        return r;
    endfunction

    function automatic logic [POS_W-1:0] clamp_pos(longint v);
        if (v < 0)
            return '0;
        if (v > longint'(POS_MAX))
            return POS_MAX;
        return v[POS_W-1:0];
    endfunction

    function automatic logic [VEL_W-1:0] clamp_vel(longint v);
        if (v < VEL_MIN)
            return VEL_W'(VEL_MIN);
        if (v > VEL_MAX)
            return VEL_W'(VEL_MAX);
        return v[VEL_W-1:0];
    endfunction

    function automatic resp_t resolve_collision(pair_t p, logic [REST_W-1:0] rest);
        resp_t r;
        longint dx, dy, rsum, d2, distance, nx, ny, rel, k, cx, cy, ov, mx, my;
        longint avx, avy, bvx, bvy;
        avx = p.a_vel_x;
        avy = p.a_vel_y;
        bvx = p.b_vel_x;
        bvy = p.b_vel_y;
        dx = longint'(p.a_pos_x) - longint'(p.b_pos_x);
        dy = longint'(p.a_pos_y) - longint'(p.b_pos_y);
        rsum = longint'(p.a_radius) + longint'(p.b_radius);
        r.a_pos_x = p.a_pos_x;
        r.a_pos_y = p.a_pos_y;
        r.a_vel_x = p.a_vel_x;
        r.a_vel_y = p.a_vel_y;
        r.b_pos_x = p.b_pos_x;
        r.b_pos_y = p.b_pos_y;
        r.b_vel_x = p.b_vel_x;
        r.b_vel_y = p.b_vel_y;
        r.hit = 1'b0;
        r.coincident = (dx == 0 && dy == 0);
        if (!r.coincident && dx > -(1 << 17) && dx < (1 << 17)
            && dy > -(1 << 17) && dy < (1 << 17))
        begin
            d2 = dx * dx + dy * dy;
            if (d2 < rsum * rsum)
            begin
                distance = isqrt(d2);
                nx = (((dx < 0) ? -dx : dx) <<< NORM_FRAC) / distance;
                ny = (((dy < 0) ? -dy : dy) <<< NORM_FRAC) / distance;
                if (dx < 0)
                    nx = -nx;
                if (dy < 0)
                    ny = -ny;
                rel = (avx - bvx) * nx + (avy - bvy) * ny;
                k = rel * longint'(rest);
                cx = round_shift(k * nx, 2 * NORM_FRAC + 8);
                cy = round_shift(k * ny, 2 * NORM_FRAC + 8);
                ov = rsum - distance;
                mx = round_shift(nx * ov, NORM_FRAC + 1);
                my = round_shift(ny * ov, NORM_FRAC + 1);
                r.a_pos_x = clamp_pos(longint'(p.a_pos_x) + mx);
                r.a_pos_y = clamp_pos(longint'(p.a_pos_y) + my);
                r.a_vel_x = clamp_vel(avx - cx);
                r.a_vel_y = clamp_vel(avy - cy);
                r.b_pos_x = clamp_pos(longint'(p.b_pos_x) - mx);
                r.b_pos_y = clamp_pos(longint'(p.b_pos_y) - my);
                r.b_vel_x = clamp_vel(bvx + cx);
                r.b_vel_y = clamp_vel(bvy + cy);
                r.hit = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic pair_t make_pair(longint ax, longint ay, longint ar, longint avx,
                                        longint avy, longint bx, longint by, longint br,
                                        longint bvx, longint bvy);
        pair_t p;
        p.a_pos_x = ax[POS_W-1:0];
        p.a_pos_y = ay[POS_W-1:0];
        p.a_radius = ar[RAD_W-1:0];
        p.a_vel_x = avx[VEL_W-1:0];
        p.a_vel_y = avy[VEL_W-1:0];
        p.b_pos_x = bx[POS_W-1:0];
        p.b_pos_y = by[POS_W-1:0];
        p.b_radius = br[RAD_W-1:0];
        p.b_vel_x = bvx[VEL_W-1:0];
        p.b_vel_y = bvy[VEL_W-1:0];
        return p;
    endfunction

    function automatic resp_t unchanged(pair_t p, bit coin);
        resp_t r;
        r.a_pos_x = p.a_pos_x;
        r.a_pos_y = p.a_pos_y;
        r.a_vel_x = p.a_vel_x;
        r.a_vel_y = p.a_vel_y;
        r.b_pos_x = p.b_pos_x;
        r.b_pos_y = p.b_pos_y;
        r.b_vel_x = p.b_vel_x;
        r.b_vel_y = p.b_vel_y;
        r.hit = 1'b0;
        r.coincident = coin;
        return r;
    endfunction

    function automatic pair_t random_pair();
        pair_t p;
        longint dx, dy, sep;
        p = pair_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        case ($urandom_range(0, 9))
            0, 1: ;
            9:
            begin
                p.b_pos_x = p.a_pos_x;
                p.b_pos_y = p.a_pos_y;
            end
            default:
            begin
                sep = (64'sd1 << $urandom_range(2, 17)) - 1;
                dx = $urandom_range(0, 1 << 17) % (sep + 1);
                dy = $urandom_range(0, 1 << 17) % (sep + 1);
                if ($urandom_range(0, 1))
                    dx = -dx;
                if ($urandom_range(0, 1))
                    dy = -dy;
                p.b_pos_x = clamp_pos(longint'(p.a_pos_x) + dx);
                p.b_pos_y = clamp_pos(longint'(p.a_pos_y) + dy);
                if ($urandom_range(0, 3) != 0)
                begin
                    p.a_radius = RAD_W'($urandom_range(0, int'(sep)));
                    p.b_radius = RAD_W'($urandom_range(0, int'(sep)));
                end
            end
        endcase
        return p;
    endfunction

    // tvalid stays high between back-to-back beats; it drops only on a gap
    task automatic send_pair(pair_t p);
        int gap;
        gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, 6);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata <= IN_W'(p);
        s_axis_tvalid <= 1'b1;
        expected_resp_q.push_back(resolve_collision(p, restitution_q));
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_restitution(logic [REST_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (expected_resp_q.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        restitution_q = value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic add_row(pair_t p, bit has_fixed, resp_t fixed);
        directed_row_t row;
        row.pair = p;
        row.has_fixed = has_fixed;
        row.fixed = fixed;
        directed_rows.push_back(row);
    endtask

    always @(negedge clk)
    begin
        if (hold_off)
            m_axis_tready <= 1'b0;
        else if ($urandom_range(0, 3) == 0)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        resp_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = resp_t'(m_axis_tdata[$bits(resp_t)-1:0]);
            if (expected_resp_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result beat %h", got);
            end
            else
            begin
                want = expected_resp_q.pop_front();
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected %h got %h", want, got);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || hold_off)
            idle_cycles <= 0;
        else if (rst_n && (!stim_done || expected_resp_q.size() != 0))
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        pair_t p;
        resp_t none;
        none = '0;
        // directed table; fixed results only where the answer is plain
        p = make_pair(1000, 1000, 500, 100, -100, 1000, 1000, 500, -100, 100);
        add_row(p, 1, unchanged(p, 1));
        p = make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(p, 1, unchanged(p, 1));
        p = make_pair(0, 0, 0, VEL_MIN, VEL_MAX, 100, 0, 0, VEL_MAX, VEL_MIN);
        add_row(p, 1, unchanged(p, 0));
        p = make_pair(POS_MAX, POS_MAX, 65535, VEL_MAX, VEL_MAX, 0, 0, 65535, 0, 0);
        add_row(p, 1, unchanged(p, 0));
        p = make_pair(131072, 0, 65535, 0, 0, 0, 0, 65535, 0, 0);
        add_row(p, 1, unchanged(p, 0));
        p = make_pair(5000, 5000, 100, 0, 0, 5300, 5000, 100, 0, 0);
        add_row(p, 1, unchanged(p, 0));
        add_row(make_pair(5000, 5000, 200, 256, 0, 5300, 5000, 200, -256, 0), 0, none);
        add_row(make_pair(5000, 5000, 200, 0, 512, 5000, 5200, 200, 0, -512), 0, none);
        add_row(make_pair(10, 10, 65535, VEL_MAX, VEL_MAX, 20, 20, 65535, VEL_MIN,
                          VEL_MIN), 0, none);
        add_row(make_pair(POS_MAX - 5, POS_MAX - 5, 65535, 0, 0, POS_MAX - 6, POS_MAX - 6,
                          65535, 0, 0), 0, none);
        add_row(make_pair(1, 1, 1, VEL_MIN, VEL_MIN, 0, 0, 1, VEL_MAX, VEL_MAX), 0, none);
        add_row(make_pair(131071, 131071, 65535, 100, 100, 0, 0, 65535, 0, 0), 0, none);
        add_row(make_pair(30000, 40000, 3000, -200, 300, 31000, 41500, 800, 50, -50), 0,
                none);

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            send_pair(directed_rows[i].pair);
            if (directed_rows[i].has_fixed)
                expected_resp_q[expected_resp_q.size() - 1] = directed_rows[i].fixed;
        end

        // receiver hold-off while pairs keep coming in
        hold_off = 1;
        fork
            repeat (LATENCY * 3) send_pair(random_pair());
            repeat (300) @(negedge clk);
        join_any
        hold_off = 0;
        wait fork;

        foreach (directed_rows[i])
        begin
            if (!directed_rows[i].has_fixed)
                ;
        end

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: write_restitution('0);
                1: write_restitution(9'd256);
                2: write_restitution('1);
                default: write_restitution(9'd128);
            endcase
            foreach (directed_rows[i])
                if (!directed_rows[i].has_fixed)
                    send_pair(directed_rows[i].pair);
            repeat (N_RANDOM / 4) send_pair(random_pair());
        end

        s_axis_tvalid <= 1'b0;
        stim_done = 1;
        while (expected_resp_q.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);
        if (mismatch_count == 0 && expected_resp_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/cpc_pkg.sv
rtl/cpc_sqrt_stage.sv
rtl/cpc_div_stage.sv
rtl/circle_pair_collision_unit.sv
test/tb_circle_pair_collision_unit.sv
